[hw/rtl/nfe_pkg.sv]
// ----------------------------------------------------------------------------
// nfe_pkg
// Types, character constants and field code tables shared by the NMEA
// sentence field extractor.
// ----------------------------------------------------------------------------
package nfe_pkg;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_GGA   = 2'd1,
    KIND_RMC   = 2'd2,
    KIND_OTHER = 2'd3
  } kind_t;

  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;

  localparam logic [2:0] HDR_IDLE = 3'd0;
  localparam logic [2:0] HDR_LAST = 3'd5;
  localparam logic [2:0] HDR_DONE = 3'd6;

  localparam logic [3:0] IDX_MAX = 4'd15;

  // Field codes on the result channel.
  localparam logic [3:0] FC_TIME     = 4'd0;
  localparam logic [3:0] FC_DATE     = 4'd1;
  localparam logic [3:0] FC_LAT      = 4'd2;
  localparam logic [3:0] FC_NS       = 4'd3;
  localparam logic [3:0] FC_LON      = 4'd4;
  localparam logic [3:0] FC_EW       = 4'd5;
  localparam logic [3:0] FC_FIX      = 4'd6;
  localparam logic [3:0] FC_SATS     = 4'd7;
  localparam logic [3:0] FC_STATUS   = 4'd8;
  localparam logic [3:0] FC_HDOP     = 4'd9;
  localparam logic [3:0] FC_ALT      = 4'd10;
  localparam logic [3:0] FC_GEOID    = 4'd11;
  localparam logic [3:0] FC_NOT_KEPT = 4'd15;

  // Expected header character at header position p (0..4).
  function automatic logic [7:0] hdr_gga_char(input logic [2:0] p);
    case (p)
      3'd0:    hdr_gga_char = "G";
      3'd1:    hdr_gga_char = "P";
      3'd2:    hdr_gga_char = "G";
      3'd3:    hdr_gga_char = "G";
      default: hdr_gga_char = "A";
    endcase
  endfunction

  function automatic logic [7:0] hdr_rmc_char(input logic [2:0] p);
    case (p)
      3'd0:    hdr_rmc_char = "G";
      3'd1:    hdr_rmc_char = "P";
      3'd2:    hdr_rmc_char = "R";
      3'd3:    hdr_rmc_char = "M";
      default: hdr_rmc_char = "C";
    endcase
  endfunction

  // Field code of a comma-counted field index within a kept sentence.
  function automatic logic [3:0] kept_code(input kind_t k, input logic [3:0] idx);
    logic [3:0] c;
    c = FC_NOT_KEPT;
    case (k)
      KIND_GGA: begin
        case (idx)
          4'd1:    c = FC_TIME;
          4'd2:    c = FC_LAT;
          4'd3:    c = FC_NS;
          4'd4:    c = FC_LON;
          4'd5:    c = FC_EW;
          4'd6:    c = FC_FIX;
          4'd7:    c = FC_SATS;
          4'd8:    c = FC_HDOP;
          4'd9:    c = FC_ALT;
          4'd11:   c = FC_GEOID;
          default: c = FC_NOT_KEPT;
        endcase
      end
      KIND_RMC: begin
        case (idx)
          4'd1:    c = FC_TIME;
          4'd2:    c = FC_STATUS;
          4'd3:    c = FC_LAT;
          4'd4:    c = FC_NS;
          4'd5:    c = FC_LON;
          4'd6:    c = FC_EW;
          4'd9:    c = FC_DATE;
          default: c = FC_NOT_KEPT;
        endcase
      end
      default: c = FC_NOT_KEPT;
    endcase
    return c;
  endfunction

endpackage

[hw/rtl/nmea_field_extractor_top.sv]
// ----------------------------------------------------------------------------
// nmea_field_extractor_top
// Extracts the position and time fields of GGA and RMC sentences from an
// NMEA character stream.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready/in_byte_value) takes one character
//   per request. A '$' opens a sentence header; GPGGA and GPRMC sentences are
//   kept, every other sentence is skipped until the next '$', CR or LF.
//   The result channel (out_valid/out_ready/out_*) carries one request per
//   character of a kept field, tagged with its field code, plus an end marker
//   (out_field_end high, out_char_value zero) on the comma that closes a
//   non-empty kept field. Most characters produce no result.
//   Each result is on the output register in the cycle after its character is
//   accepted. Throughput is one character per cycle while the receiver does not
//   stall, set by the single parser state update done in the cycle of acceptance.
//   When the receiver stalls with a result pending, in_ready drops; it stays
//   high while the output register is empty or being drained in that cycle.
//   Reset (rst_n low, synchronous) returns the parser to idle, waiting for a
//   '$', and empties the output register.
// ----------------------------------------------------------------------------
module nmea_field_extractor_top
  import nfe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte_value,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_sentence_kind,
  output logic [3:0] out_field_code,
  output logic [7:0] out_char_value,
  output logic       out_field_end
);

  logic [2:0] hdr_pos_r, hdr_pos_nxt;
  logic       match_gga_r, match_gga_nxt;
  logic       match_rmc_r, match_rmc_nxt;
  kind_t      kind_r, kind_nxt;
  logic [3:0] idx_r, idx_nxt;
  logic       nonempty_r, nonempty_nxt;

  logic       out_valid_r;
  logic       kind_bit_r;
  logic [3:0] code_r;
  logic [7:0] char_r;
  logic       end_r;

  logic       emit;
  logic [3:0] emit_code;
  logic [7:0] emit_char;
  logic       emit_end;
  logic       in_fire;
  logic [2:0] hdr_off;
  logic [3:0] cur_code;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign hdr_off  = hdr_pos_r - 3'd1;
  assign cur_code = kept_code(kind_r, idx_r);

  always_comb begin
    hdr_pos_nxt   = hdr_pos_r;
    match_gga_nxt = match_gga_r;
    match_rmc_nxt = match_rmc_r;
    kind_nxt      = kind_r;
    idx_nxt       = idx_r;
    nonempty_nxt  = nonempty_r;
    emit          = 1'b0;
    emit_code     = cur_code;
    emit_char     = in_byte_value;
    emit_end      = 1'b0;
    if (in_byte_value == CHAR_DOLLAR) begin
      hdr_pos_nxt   = 3'd1;
      match_gga_nxt = 1'b1;
      match_rmc_nxt = 1'b1;
      kind_nxt      = KIND_NONE;
      idx_nxt       = '0;
      nonempty_nxt  = 1'b0;
    end else if (in_byte_value == CHAR_CR || in_byte_value == CHAR_LF) begin
      hdr_pos_nxt   = HDR_IDLE;
      match_gga_nxt = 1'b0;
      match_rmc_nxt = 1'b0;
      kind_nxt      = KIND_NONE;
      idx_nxt       = '0;
      nonempty_nxt  = 1'b0;
    end else if (hdr_pos_r == HDR_IDLE) begin
      // Characters outside a sentence are dropped.
    end else if (hdr_pos_r <= HDR_LAST) begin
      match_gga_nxt = match_gga_r && (in_byte_value == hdr_gga_char(hdr_off));
      match_rmc_nxt = match_rmc_r && (in_byte_value == hdr_rmc_char(hdr_off));
      hdr_pos_nxt   = hdr_pos_r + 3'd1;
      if (hdr_pos_r == HDR_LAST) begin
        if (match_gga_nxt) begin
          kind_nxt = KIND_GGA;
        end else if (match_rmc_nxt) begin
          kind_nxt = KIND_RMC;
        end else begin
          kind_nxt = KIND_OTHER;
        end
        idx_nxt      = '0;
        nonempty_nxt = 1'b0;
      end
    end else if (in_byte_value == CHAR_COMMA) begin
      if (cur_code != FC_NOT_KEPT && nonempty_r) begin
        emit      = 1'b1;
        emit_char = '0;
        emit_end  = 1'b1;
      end
      if (idx_r != IDX_MAX) begin
        idx_nxt = idx_r + 4'd1;
      end
      nonempty_nxt = 1'b0;
    end else if (cur_code != FC_NOT_KEPT) begin
      nonempty_nxt = 1'b1;
      emit         = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_pos_r   <= HDR_IDLE;
      match_gga_r <= 1'b0;
      match_rmc_r <= 1'b0;
      kind_r      <= KIND_NONE;
      idx_r       <= '0;
      nonempty_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        hdr_pos_r   <= hdr_pos_nxt;
        match_gga_r <= match_gga_nxt;
        match_rmc_r <= match_rmc_nxt;
        kind_r      <= kind_nxt;
        idx_r       <= idx_nxt;
        nonempty_r  <= nonempty_nxt;
        out_valid_r <= emit;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload; only loaded when a new result is produced.
  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      kind_bit_r <= (kind_r == KIND_RMC);
      code_r     <= emit_code;
      char_r     <= emit_char;
      end_r      <= emit_end;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_sentence_kind = kind_bit_r;
  assign out_field_code    = code_r;
  assign out_char_value    = char_r;
  assign out_field_end     = end_r;

  // An end marker never carries a character.
  a_end_no_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && end_r |-> char_r == 8'd0)
    else $error("end marker with nonzero character");

  // Only kept field codes reach the output.
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> code_r <= FC_GEOID)
    else $error("field code out of range");

  // A sentence body exists only after a complete header.
  a_kind_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    kind_r != KIND_NONE |-> hdr_pos_r == HDR_DONE)
    else $error("sentence kind set without complete header");

  // A dollar restarts the header and never produces a result.
  a_dollar_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_byte_value == CHAR_DOLLAR |=>
      hdr_pos_r == 3'd1 && kind_r == KIND_NONE && !out_valid_r)
    else $error("dollar did not restart the header");

endmodule
